// ===== rtl/csdf_pkg.sv =====
// shared types, constants and cell arithmetic for the circle span difference fill
package csdf_pkg;

	localparam int DEF_IMAGE_WIDTH = 128;
	localparam int DEF_ROOT_TABLE_SIZE = 8192;
	localparam int CELL_W = 56;
	localparam int EXT_W = 12;

	typedef struct packed {
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
		logic [7:0] n;
	} cell_t;

	function automatic cell_t cell_add(cell_t a, cell_t b);
		cell_t s;
		s.r = a.r + b.r;
		s.g = a.g + b.g;
		s.b = a.b + b.b;
		s.n = a.n + b.n;
		return s;
	endfunction

	function automatic cell_t cell_sub(cell_t a, cell_t b);
		cell_t s;
		s.r = a.r - b.r;
		s.g = a.g - b.g;
		s.b = a.b - b.b;
		s.n = a.n - b.n;
		return s;
	endfunction

endpackage

// ===== rtl/csdf_ram.sv =====
// generic simple dual-port ram with registered read
module csdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/circle_span_difference_fill.sv =====
// top level: filled-circle compositor on a row-wise difference store
//
// Input channel (in_valid/in_ready) takes one command per beat. cmd 0 draws a
// circle: each covered row gets an add at its start column and a subtract just
// past its end column. cmd 1 reads the next pixel in raster order and yields
// one result beat on the output channel (out_valid/out_ready): the running row
// sum of colour and cover count, with last_pixel set on the final pixel.
// A draw walks each row it covers in turn: square, root table read, then two
// read-modify-writes of the store. A read does one store read, then the
// accumulate into the output register. Both memories have a single read port;
// work is one item at a time. After reset the block runs a clearing pass that
// zeroes the store and builds the square root table; in_ready is low during
// it. A stalled receiver holds the result in the output register; the block
// keeps taking draws meanwhile, and a further read waits for the output
// register to free up.
module circle_span_difference_fill
	import csdf_pkg::*;
#(
	parameter int IMAGE_WIDTH = DEF_IMAGE_WIDTH,
	parameter int ROOT_TABLE_SIZE = DEF_ROOT_TABLE_SIZE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  center_x,
	input  logic [7:0]  center_y,
	input  logic [6:0]  radius,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] red_sum,
	output logic [15:0] green_sum,
	output logic [15:0] blue_sum,
	output logic [7:0]  cover_count,
	output logic        last_pixel
);

	localparam int PIX = IMAGE_WIDTH * IMAGE_WIDTH;
	localparam int CW = $clog2(IMAGE_WIDTH);
	localparam int AW = $clog2(PIX);
	localparam int TW = $clog2(ROOT_TABLE_SIZE);
	localparam int RW = ($clog2(ROOT_TABLE_SIZE) + 1) / 2;
	localparam int SQW = 2 * RW + 1;
	localparam int SWEEP = (PIX > ROOT_TABLE_SIZE) ? PIX : ROOT_TABLE_SIZE;
	localparam int SW = $clog2(SWEEP);
	localparam int CMPW = (SW > SQW) ? SW : SQW;
	localparam logic [31:0] TMAX = 32'(ROOT_TABLE_SIZE - 1);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b00000001,
		S_IDLE  = 8'b00000010,
		S_RD    = 8'b00000100,
		S_ROW   = 8'b00001000,
		S_SQ    = 8'b00010000,
		S_ROOT  = 8'b00100000,
		S_AWR   = 8'b01000000,
		S_BWR   = 8'b10000000
	} state_t;

	state_t state_q;

	logic [SW-1:0] sweep_q;
	logic [RW-1:0] k_q;
	logic [SQW-1:0] next_sq_q;

	logic [7:0] cx_q;
	logic [7:0] cy_q;
	logic [13:0] rsq_q;
	cell_t color_q;
	logic [CW-1:0] row_q;
	logic [CW-1:0] last_q;
	logic [AW-1:0] row_base_q;
	logic [15:0] dysq_q;
	logic [CW-1:0] end_q;
	logic end_in_q;
	logic [AW-1:0] a_addr_q;

	logic [AW-1:0] rd_addr_q;
	logic [CW-1:0] rd_col_q;
	logic rd_first_q;
	logic rd_last_q;
	cell_t acc_q;
	logic out_valid_q;

	logic st_we;
	logic [AW-1:0] st_waddr;
	cell_t st_wdata;
	logic st_re;
	logic [AW-1:0] st_raddr;
	cell_t st_rdata;

	logic tb_we;
	logic [TW-1:0] tb_waddr;
	logic [RW-1:0] tb_wdata;
	logic tb_re;
	logic [TW-1:0] tb_raddr;
	logic [RW-1:0] tb_rdata;

	logic accept;
	logic bump;
	logic signed [EXT_W-1:0] first_s;
	logic signed [EXT_W-1:0] last_s;
	logic signed [EXT_W-1:0] dy_s;
	logic signed [16:0] d_s;
	logic [31:0] d_sat;
	logic signed [EXT_W-1:0] start_s;
	logic signed [EXT_W-1:0] end_s;
	logic [CW-1:0] start_col;
	logic start_in;
	logic row_done;
	logic out_load;
	cell_t acc_next;
	cell_t color_in;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_load = (state_q == S_RD) && (!out_valid_q || out_ready);
	assign bump = (CMPW'(sweep_q) == CMPW'(next_sq_q));
	assign row_done = (row_q == last_q);

	assign color_in.r = 16'(red);
	assign color_in.g = 16'(green);
	assign color_in.b = 16'(blue);
	assign color_in.n = 8'd1;

	always_comb begin
		first_s = signed'(EXT_W'(center_y)) - signed'(EXT_W'(radius));
		if (first_s < 0) begin
			first_s = '0;
		end
		last_s = signed'(EXT_W'(center_y)) + signed'(EXT_W'(radius));
		if (last_s > signed'(EXT_W'(IMAGE_WIDTH - 1))) begin
			last_s = signed'(EXT_W'(IMAGE_WIDTH - 1));
		end
		dy_s = signed'(EXT_W'(row_q)) - signed'(EXT_W'(cy_q));
		d_s = signed'(17'(rsq_q)) - signed'(17'(dysq_q));
		d_sat = (32'(d_s) > TMAX) ? TMAX : 32'(d_s);
		start_s = signed'(EXT_W'(cx_q)) - signed'(EXT_W'(tb_rdata));
		if (start_s < 0) begin
			start_s = '0;
		end
		end_s = signed'(EXT_W'(cx_q)) + signed'(EXT_W'(tb_rdata)) + EXT_W'(1);
		start_in = (start_s < signed'(EXT_W'(IMAGE_WIDTH)));
		start_col = CW'(start_s);
		acc_next = cell_add(rd_first_q ? cell_t'('0) : acc_q, st_rdata);
	end

	// memory port control
	always_comb begin
		st_we = 1'b0;
		st_waddr = row_base_q + AW'(end_q);
		st_wdata = cell_sub(st_rdata, color_q);
		st_re = 1'b0;
		st_raddr = rd_addr_q;
		tb_we = 1'b0;
		tb_waddr = TW'(sweep_q);
		tb_wdata = bump ? k_q + RW'(1) : k_q;
		tb_re = 1'b0;
		tb_raddr = TW'(d_sat);
		case (state_q)
			S_CLEAR: begin
				st_we = (32'(sweep_q) < 32'(PIX));
				st_waddr = AW'(sweep_q);
				st_wdata = '0;
				tb_we = (32'(sweep_q) < 32'(ROOT_TABLE_SIZE));
			end
			S_IDLE: begin
				st_re = accept && cmd;
			end
			S_SQ: begin
				tb_re = (d_s > 0);
			end
			S_ROOT: begin
				st_re = start_in;
				st_raddr = row_base_q + AW'(start_col);
			end
			S_AWR: begin
				st_we = 1'b1;
				st_waddr = a_addr_q;
				st_wdata = cell_add(st_rdata, color_q);
				st_re = end_in_q;
				st_raddr = row_base_q + AW'(end_q);
			end
			S_BWR: begin
				st_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			sweep_q <= '0;
			k_q <= '0;
			next_sq_q <= SQW'(1);
			rd_addr_q <= '0;
			rd_col_q <= '0;
			rd_first_q <= 1'b0;
			rd_last_q <= 1'b0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if ((32'(sweep_q) < 32'(ROOT_TABLE_SIZE)) && bump) begin
						k_q <= k_q + RW'(1);
						next_sq_q <= next_sq_q + SQW'({k_q, 1'b0}) + SQW'(3);
					end
					if (32'(sweep_q) == 32'(SWEEP - 1)) begin
						state_q <= S_IDLE;
					end
					sweep_q <= sweep_q + SW'(1);
				end
				S_IDLE: begin
					if (accept) begin
						if (cmd) begin
							rd_first_q <= (rd_col_q == '0);
							rd_last_q <= (32'(rd_addr_q) == 32'(PIX - 1));
							rd_addr_q <= (32'(rd_addr_q) == 32'(PIX - 1)) ? '0 :
								rd_addr_q + AW'(1);
							rd_col_q <= (32'(rd_col_q) == 32'(IMAGE_WIDTH - 1)) ? '0 :
								rd_col_q + CW'(1);
							state_q <= S_RD;
						end else if (first_s <= last_s) begin
							state_q <= S_ROW;
						end
					end
				end
				S_RD: begin
					if (out_load) begin
						acc_q <= acc_next;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_ROW: begin
					state_q <= S_SQ;
				end
				S_SQ: begin
					if (d_s > 0) begin
						state_q <= S_ROOT;
					end else if (row_done) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ROW;
					end
				end
				S_ROOT: begin
					if (start_in) begin
						state_q <= S_AWR;
					end else if (row_done) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ROW;
					end
				end
				S_AWR: begin
					if (end_in_q) begin
						state_q <= S_BWR;
					end else if (row_done) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ROW;
					end
				end
				S_BWR: begin
					state_q <= row_done ? S_IDLE : S_ROW;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// draw datapath and result payload
	always_ff @(posedge clk) begin
		if (accept && !cmd) begin
			cx_q <= center_x;
			cy_q <= center_y;
			rsq_q <= 14'(radius * radius);
			color_q <= color_in;
			row_q <= CW'(first_s);
			last_q <= CW'(last_s);
		end
		if (state_q == S_ROW) begin
			row_base_q <= AW'(row_q) * AW'(IMAGE_WIDTH);
			dysq_q <= 16'($signed(dy_s[7:0]) * $signed(dy_s[7:0]));
		end
		if (state_q == S_ROOT) begin
			a_addr_q <= row_base_q + AW'(start_col);
			end_in_q <= (end_s < signed'(EXT_W'(IMAGE_WIDTH)));
			end_q <= CW'(end_s);
		end
		if (((state_q == S_SQ) && !(d_s > 0)) || ((state_q == S_ROOT) && !start_in) ||
			((state_q == S_AWR) && !end_in_q) || (state_q == S_BWR)) begin
			if (!row_done) begin
				row_q <= row_q + CW'(1);
			end
		end
		if (out_load) begin
			red_sum <= acc_next.r;
			green_sum <= acc_next.g;
			blue_sum <= acc_next.b;
			cover_count <= acc_next.n;
			last_pixel <= rd_last_q;
		end
	end

	csdf_ram #(
		.WIDTH(CELL_W),
		.DEPTH(PIX)
	) u_store (
		.clk(clk),
		.we(st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re(st_re),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	csdf_ram #(
		.WIDTH(RW),
		.DEPTH(ROOT_TABLE_SIZE)
	) u_root (
		.clk(clk),
		.we(tb_we),
		.waddr(tb_waddr),
		.wdata(tb_wdata),
		.re(tb_re),
		.raddr(tb_raddr),
		.rdata(tb_rdata)
	);

endmodule
